### rtl/core/vec3_arith_unit_assert.svh
// ---------------------------------------------------------------------------
// vec3_arith_unit assertion macros
// Shared property wrappers, clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef VEC3_ARITH_UNIT_ASSERT_SVH
`define VEC3_ARITH_UNIT_ASSERT_SVH

// Same-cycle implication.
`define V3AU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication.
`define V3AU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error(msg);

`endif

### rtl/core/v3au_pkg.sv
// ---------------------------------------------------------------------------
// v3au_pkg
// Widths, op codes and shared types of the three-lane vector unit.
// ---------------------------------------------------------------------------
`default_nettype none

package v3au_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned WORD_BITS_DEF = 32;

  localparam int unsigned DW = 32;      // port word width
  localparam int unsigned BW = DW + 2;  // lane base value: sum of three words
  localparam int unsigned MW = DW + 1;  // multiplier operand: difference of two words
  localparam int unsigned PW = 2 * MW;  // full product
  localparam int unsigned SW = PW + 4;  // final combine and saturate

  typedef enum logic [4:0] {
    F_ADD       = 5'd0,
    F_SUB       = 5'd1,
    F_MUL       = 5'd2,
    F_SCALE     = 5'd3,
    F_ADDS      = 5'd4,
    F_SUBS      = 5'd5,
    F_NEG       = 5'd6,
    F_DOT       = 5'd7,
    F_NORM2     = 5'd8,
    F_DIST2     = 5'd9,
    F_CROSS     = 5'd10,
    F_CENTER    = 5'd11,
    F_MIN       = 5'd12,
    F_MAX       = 5'd13,
    F_CLAMP     = 5'd14,
    F_LERP      = 5'd15,
    F_LERPC     = 5'd16,
    F_STEP_UNI  = 5'd17,
    F_STEP      = 5'd18,
    F_SWIZZLE   = 5'd19,
    F_ACC_ADD   = 5'd20,
    F_ACC_SUB   = 5'd21,
    F_ACC_MUL   = 5'd22,
    F_ACC_SCALE = 5'd23,
    F_ACC_MAX   = 5'd24,
    F_ACC_MIN   = 5'd25,
    F_NORM1     = 5'd26,
    F_NORMINF   = 5'd27
  } func_e;

  typedef logic signed [DW-1:0] word_t;

  typedef struct packed {
    logic  load;
    func_e func;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [BW-1:0] base;
    logic signed [PW-1:0] m0;
    logic signed [PW-1:0] m1;
  } lane_out_t;

  typedef struct packed {
    logic  hit;
    word_t val;
  } sat_t;

endpackage

`default_nettype wire

### rtl/core/vec3_arith_unit.sv
// ---------------------------------------------------------------------------
// vec3_arith_unit
// Three-lane Q16.16 vector arithmetic unit with saturating results.
// ---------------------------------------------------------------------------
// Pipeline: an accepted request passes the input register, the product
//   register and the result register; done_o is raised as the result
//   register loads.
// Throughput: one request per clock; busy_o stays low, the receiver cannot
//   stall and every result is shown for exactly one cycle.
// Reset: rst_ni clears the valid pipeline only; payload registers hold junk
//   until the first request flows through.
`default_nettype none

`include "vec3_arith_unit_assert.svh"

module vec3_arith_unit #(
  parameter int unsigned FRAC_BITS = v3au_pkg::FRAC_BITS_DEF,
  parameter int unsigned WORD_BITS = v3au_pkg::WORD_BITS_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [4:0]         func_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] a_z_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  input  logic signed [31:0] acc_x_i,
  input  logic signed [31:0] acc_y_i,
  input  logic signed [31:0] acc_z_i,
  input  logic signed [31:0] scalar_i,
  input  logic signed [31:0] limit_hi_i,
  output logic               done_o,
  output logic signed [31:0] r_x_o,
  output logic signed [31:0] r_y_o,
  output logic signed [31:0] r_z_o,
  output logic signed [31:0] r_scalar_o,
  output logic               saturated_o
);
  import v3au_pkg::*;

  // saturation bounds of the internal word, and their look on the 32-bit ports
  localparam logic signed [SW-1:0] SMAX   = (SW'(1) << (WORD_BITS - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SMIN   = ~SMAX;
  localparam word_t                SAT_HI = SMAX[DW-1:0];
  localparam word_t                SAT_LO = SMIN[DW-1:0];

  function automatic sat_t sat_fn(input logic signed [SW-1:0] v);
    sat_t r;
    r.hit = 1'b0;
    r.val = v[DW-1:0];
    if (v > SMAX) begin
      r.hit = 1'b1;
      r.val = SAT_HI;
    end else if (v < SMIN) begin
      r.hit = 1'b1;
      r.val = SAT_LO;
    end
    return r;
  endfunction

  // ---- input register ----------------------------------------------------
  logic  v0_q, v1_q, done_q;
  func_e func0_q, func1_q;
  word_t a_q [3];
  word_t b_q [3];
  word_t c_q [3];
  word_t s_q, hi_q;

  // never hold off a request: every stage advances each cycle
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v0_q   <= start_i && !busy_o;
      v1_q   <= v0_q;
      done_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      func0_q <= func_e'(func_i);
      a_q[0]  <= a_x_i;
      a_q[1]  <= a_y_i;
      a_q[2]  <= a_z_i;
      b_q[0]  <= b_x_i;
      b_q[1]  <= b_y_i;
      b_q[2]  <= b_z_i;
      c_q[0]  <= acc_x_i;
      c_q[1]  <= acc_y_i;
      c_q[2]  <= acc_z_i;
      s_q     <= scalar_i;
      hi_q    <= limit_hi_i;
    end
  end

  // ---- stage 1: lanes with their multipliers -----------------------------
  lane_ctl_t lane_ctl;
  lane_out_t lane_q [3];

  assign lane_ctl.load = v0_q;
  assign lane_ctl.func = func0_q;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    // cross lane i is a[j]*b[k] - a[k]*b[j]
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    v3au_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .ctl_i  (lane_ctl),
      .a_i    (a_q[i]),
      .b_i    (b_q[i]),
      .c_i    (c_q[i]),
      .s_i    (s_q),
      .hi_i   (hi_q),
      .a_all_i(a_q),
      .swz_i  (s_q[2*i +: 2]),
      .xa_i   (a_q[J]),
      .xb_i   (b_q[K]),
      .ya_i   (a_q[K]),
      .yb_i   (b_q[J]),
      .lane_o (lane_q[i])
    );
  end

  // absolute-value norms need no product: settle them beside the lanes
  logic signed [BW-1:0] abs_a [3];
  logic signed [BW-1:0] n1_d, ninf_d, sbase_d, sbase_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_a[i] = (a_q[i] < 0) ? -BW'(a_q[i]) : BW'(a_q[i]);
    end
    n1_d   = abs_a[0] + abs_a[1] + abs_a[2];
    ninf_d = (abs_a[1] > abs_a[2]) ? abs_a[1] : abs_a[2];
    ninf_d = (abs_a[0] > ninf_d) ? abs_a[0] : ninf_d;
    case (func0_q)
      F_NORM1:   sbase_d = n1_d;
      F_NORMINF: sbase_d = ninf_d;
      default:   sbase_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (v0_q) begin
      func1_q <= func0_q;
      sbase_q <= sbase_d;
    end
  end

  // ---- stage 2: combine, floor, saturate ---------------------------------
  // Summing full products before one floor shift equals flooring the high
  // parts and the summed fraction bits separately.
  logic signed [SW-1:0] pd [3];
  logic signed [SW-1:0] lv [3];
  logic signed [SW-1:0] ssum, sv;
  sat_t                 lsat [3];
  sat_t                 ssat;
  logic                 is_scal;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pd[i]   = SW'(lane_q[i].m0) - SW'(lane_q[i].m1);
      lv[i]   = SW'(lane_q[i].base) + (pd[i] >>> FRAC_BITS);
      lsat[i] = sat_fn(lv[i]);
    end
    ssum    = pd[0] + pd[1] + pd[2];
    sv      = SW'(sbase_q) + (ssum >>> FRAC_BITS);
    ssat    = sat_fn(sv);
    is_scal = func1_q inside {F_DOT, F_NORM2, F_DIST2, F_NORM1, F_NORMINF};
  end

  // ---- result register ---------------------------------------------------
  word_t r_q [3];
  word_t rs_q;
  logic  sat_q;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      for (int i = 0; i < 3; i++) begin
        r_q[i] <= is_scal ? '0 : lsat[i].val;
      end
      rs_q  <= is_scal ? ssat.val : '0;
      sat_q <= is_scal ? ssat.hit : (lsat[0].hit | lsat[1].hit | lsat[2].hit);
    end
  end

  assign done_o      = done_q;
  assign r_x_o       = r_q[0];
  assign r_y_o       = r_q[1];
  assign r_z_o       = r_q[2];
  assign r_scalar_o  = rs_q;
  assign saturated_o = sat_q;

  // ---- checks ------------------------------------------------------------
  `V3AU_ASSERT_NXT(a_latency, start_i && !busy_o, ##2 done_o,
                   "accepted request did not produce a strobe three cycles later")
  `V3AU_ASSERT_IMP(a_sat_bound, done_o && saturated_o,
                   (r_x_o == SAT_HI || r_x_o == SAT_LO || r_y_o == SAT_HI ||
                    r_y_o == SAT_LO || r_z_o == SAT_HI || r_z_o == SAT_LO ||
                    r_scalar_o == SAT_HI || r_scalar_o == SAT_LO),
                   "saturation flagged but no output sits at a bound")
  `V3AU_ASSERT_IMP(a_scalar_excl, done_o && (r_scalar_o != 0),
                   (r_x_o == 0 && r_y_o == 0 && r_z_o == 0),
                   "scalar result alongside a nonzero vector result")

endmodule

`default_nettype wire

### rtl/core/v3au_lane.sv
// ---------------------------------------------------------------------------
// v3au_lane
// One vector lane: non-product result plus two registered products.
// ---------------------------------------------------------------------------
`default_nettype none

module v3au_lane #(
  parameter int unsigned FRAC_BITS = v3au_pkg::FRAC_BITS_DEF
) (
  input  wire                 clk_i,
  input  v3au_pkg::lane_ctl_t ctl_i,
  input  v3au_pkg::word_t     a_i,
  input  v3au_pkg::word_t     b_i,
  input  v3au_pkg::word_t     c_i,
  input  v3au_pkg::word_t     s_i,
  input  v3au_pkg::word_t     hi_i,
  input  v3au_pkg::word_t     a_all_i [3],
  input  logic [1:0]          swz_i,
  input  v3au_pkg::word_t     xa_i,
  input  v3au_pkg::word_t     xb_i,
  input  v3au_pkg::word_t     ya_i,
  input  v3au_pkg::word_t     yb_i,
  output v3au_pkg::lane_out_t lane_o
);
  import v3au_pkg::*;

  localparam logic signed [BW-1:0] ONE_FX = BW'(1) << FRAC_BITS;

  logic signed [BW-1:0] a_e, b_e, c_e, s_e;
  logic signed [BW-1:0] mx_ab, mn_ab;
  word_t                lo_cl, cl, swz;
  logic signed [MW-1:0] dba, dab, tc;
  logic signed [MW-1:0] p0a, p0b, p1a, p1b;
  logic signed [BW-1:0] base_d;
  logic signed [PW-1:0] m0_d, m1_d;
  lane_out_t            lane_q;

  assign a_e   = BW'(a_i);
  assign b_e   = BW'(b_i);
  assign c_e   = BW'(c_i);
  assign s_e   = BW'(s_i);
  assign mx_ab = (a_i > b_i) ? a_e : b_e;
  assign mn_ab = (a_i < b_i) ? a_e : b_e;
  assign lo_cl = (a_i > s_i) ? a_i : s_i;
  assign cl    = (lo_cl < hi_i) ? lo_cl : hi_i;
  assign dba   = MW'(b_i) - MW'(a_i);
  assign dab   = MW'(a_i) - MW'(b_i);

  always_comb begin
    if (s_i < 0) begin
      tc = '0;
    end else if (s_e > ONE_FX) begin
      tc = MW'(ONE_FX);
    end else begin
      tc = MW'(s_i);
    end
  end

  always_comb begin
    case (swz_i)
      2'd0:    swz = a_all_i[0];
      2'd1:    swz = a_all_i[1];
      2'd2:    swz = a_all_i[2];
      default: swz = '0;
    endcase
  end

  // non-product part of the lane result
  always_comb begin
    case (ctl_i.func)
      F_ADD:       base_d = a_e + b_e;
      F_SUB:       base_d = a_e - b_e;
      F_ADDS:      base_d = a_e + s_e;
      F_SUBS:      base_d = a_e - s_e;
      F_NEG:       base_d = -a_e;
      F_CENTER:    base_d = (a_e + b_e) >>> 1;
      F_MIN:       base_d = mn_ab;
      F_MAX:       base_d = mx_ab;
      F_CLAMP:     base_d = BW'(cl);
      F_LERP,
      F_LERPC:     base_d = a_e;
      F_STEP_UNI:  base_d = (a_i < s_i) ? '0 : ONE_FX;
      F_STEP:      base_d = (a_i < b_i) ? '0 : ONE_FX;
      F_SWIZZLE:   base_d = BW'(swz);
      F_ACC_ADD:   base_d = c_e + a_e + b_e;
      F_ACC_SUB:   base_d = c_e + a_e - b_e;
      F_ACC_MUL,
      F_ACC_SCALE: base_d = c_e;
      F_ACC_MAX:   base_d = c_e + mx_ab;
      F_ACC_MIN:   base_d = c_e + mn_ab;
      default:     base_d = '0;
    endcase
  end

  // multiplier operands; the second product is used by cross only
  always_comb begin
    p0a = '0;
    p0b = '0;
    p1a = '0;
    p1b = '0;
    case (ctl_i.func)
      F_MUL, F_ACC_MUL, F_DOT: begin
        p0a = MW'(a_i);
        p0b = MW'(b_i);
      end
      F_SCALE, F_ACC_SCALE: begin
        p0a = MW'(a_i);
        p0b = MW'(s_i);
      end
      F_NORM2: begin
        p0a = MW'(a_i);
        p0b = MW'(a_i);
      end
      F_DIST2: begin
        p0a = dab;
        p0b = dab;
      end
      F_LERP: begin
        p0a = dba;
        p0b = MW'(s_i);
      end
      F_LERPC: begin
        p0a = dba;
        p0b = tc;
      end
      F_CROSS: begin
        p0a = MW'(xa_i);
        p0b = MW'(xb_i);
        p1a = MW'(ya_i);
        p1b = MW'(yb_i);
      end
      default: begin
      end
    endcase
  end

  assign m0_d = p0a * p0b;
  assign m1_d = p1a * p1b;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      lane_q.base <= base_d;
      lane_q.m0   <= m0_d;
      lane_q.m1   <= m1_d;
    end
  end

  assign lane_o = lane_q;

endmodule

`default_nettype wire
